@@ hdl/dcd_pkg.sv @@
// Shared types, constants and the Damm quasigroup step for the decimal check-digit block.
// No dependencies; every other file imports this package.
package dcd_pkg;

    localparam int NUM_W      = 27;
    localparam int DIG_W      = 4;
    localparam int NUM_DIGITS = 8;
    localparam int RADIX      = 10;
    localparam int TOP_WEIGHT = 10000000;

    localparam logic [NUM_W-1:0] NUM_LIMIT = NUM_W'(100000000);

    localparam logic [DIG_W-1:0] QUASI [0:RADIX-1][0:RADIX-1] = '{
        '{4'd0, 4'd3, 4'd1, 4'd7, 4'd5, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2},
        '{4'd7, 4'd0, 4'd9, 4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd6, 4'd3},
        '{4'd4, 4'd2, 4'd0, 4'd6, 4'd8, 4'd7, 4'd1, 4'd3, 4'd5, 4'd9},
        '{4'd1, 4'd7, 4'd5, 4'd0, 4'd9, 4'd8, 4'd3, 4'd4, 4'd2, 4'd6},
        '{4'd6, 4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8},
        '{4'd3, 4'd6, 4'd7, 4'd4, 4'd2, 4'd0, 4'd9, 4'd5, 4'd8, 4'd1},
        '{4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd2, 4'd0, 4'd1, 4'd3, 4'd4},
        '{4'd8, 4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd0, 4'd1, 4'd7},
        '{4'd9, 4'd4, 4'd3, 4'd8, 4'd6, 4'd1, 4'd7, 4'd2, 4'd0, 4'd5},
        '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd0}
    };

    typedef struct packed {
        logic [NUM_W-1:0] value;
        logic [DIG_W-1:0] interim;
        logic             err;
    } cell_word_t;

    function automatic logic [DIG_W-1:0] damm_next(input logic [DIG_W-1:0] interim,
                                                   input logic [DIG_W-1:0] digit);
        logic [DIG_W-1:0] res;
        res = '0;
        if (interim < DIG_W'(RADIX) && digit < DIG_W'(RADIX))
        begin
            res = QUASI[interim][digit];
        end
        return res;
    endfunction

endpackage

@@ hdl/dcd_in_if.sv @@
// Input channel: one binary number per word, valid/ready handshake.
// Depends on dcd_pkg.
interface dcd_in_if;
    import dcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);
endinterface

@@ hdl/dcd_out_if.sv @@
// Output channel: check digit and range flag per word, valid/ready handshake.
// Depends on dcd_pkg.
interface dcd_out_if;
    import dcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [DIG_W-1:0] check_digit;
    logic             range_error;

    modport source (output valid, output check_digit, output range_error, input ready);
    modport sink   (input valid, input check_digit, input range_error, output ready);
endinterface

@@ hdl/damm_check_digit_8.sv @@
// Top level: Damm check digit over eight decimal digits, a chain of eight digit cells.
// Depends on dcd_pkg, dcd_in_if, dcd_out_if and dcd_cell.
//
//  channel   dir  fields                      meaning
//  num_in    in   number_in[26:0]             binary number, checked as eight digits
//  res_out   out  check_digit[3:0], range_error  check digit, flag for 100000000 or more
//
// Each decimal digit cell holds one register; a new word can enter every cycle while res_out is ready.
// Each cell registers its word and the cells hand on under a per-cell valid/ready
// handshake, so a stall on res_out backs up only as far as the chain is full.
// Reset clears the cell valid flags; no payload is reset.
module damm_check_digit_8 (
    input  logic clk,
    input  logic rst_n,
    dcd_in_if.sink    num_in,
    dcd_out_if.source res_out
);
    import dcd_pkg::*;

    logic       link_valid [0:NUM_DIGITS];
    logic       link_ready [0:NUM_DIGITS];
    cell_word_t link_word  [0:NUM_DIGITS];
    logic       over;

    assign over = num_in.number_in >= NUM_LIMIT;

    assign link_valid[0]         = num_in.valid;
    assign num_in.ready          = link_ready[0];
    assign link_word[0].value    = over ? '0 : num_in.number_in;
    assign link_word[0].interim  = '0;
    assign link_word[0].err      = over;

    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_cell
        dcd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_word  (link_word[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_word  (link_word[k+1])
        );
    end

    assign res_out.valid            = link_valid[NUM_DIGITS];
    assign link_ready[NUM_DIGITS]   = res_out.ready;
    assign res_out.check_digit      = link_word[NUM_DIGITS].err ? '0
                                                                : link_word[NUM_DIGITS].interim;
    assign res_out.range_error      = link_word[NUM_DIGITS].err;

endmodule

@@ hdl/dcd_cell.sv @@
// One cell of the digit chain: peels off the leading decimal digit and advances the Damm walk.
// Depends on dcd_pkg.
module dcd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  dcd_pkg::cell_word_t up_word,
    output logic               dn_valid,
    input  logic               dn_ready,
    output dcd_pkg::cell_word_t dn_word
);
    import dcd_pkg::*;

    logic             vld_reg;
    cell_word_t       word_reg;
    cell_word_t       word_next;
    logic [DIG_W-1:0] digit;
    logic [NUM_W-1:0] base;
    logic [NUM_W-1:0] rem;

    always_comb
    begin
        digit = '0;
        base  = '0;
        for (int d = 1; d < RADIX; d++)
        begin
            if (up_word.value >= NUM_W'(d * TOP_WEIGHT))
            begin
                digit = DIG_W'(d);
                base  = NUM_W'(d * TOP_WEIGHT);
            end
        end
        rem = up_word.value - base;
        // shift the remaining digits up one place
        word_next.value   = (rem << 3) + (rem << 1);
        word_next.interim = damm_next(up_word.interim, digit);
        word_next.err     = up_word.err;
    end

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= word_next;
        end
    end

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=> dn_valid)
        else $error("dcd_cell: accepted word not held");

    a_value_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> dn_word.value < NUM_LIMIT)
        else $error("dcd_cell: remainder out of range");

    a_interim_digit: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> dn_word.interim < DIG_W'(RADIX))
        else $error("dcd_cell: interim not a decimal digit");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid && dn_word.err |-> dn_word.value == '0)
        else $error("dcd_cell: flagged word carries a value");

endmodule
